FILE: src/circle_pair_overlap_resolver_assert.svh
// ============================================================================
// Circle pair overlap resolver assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is set.
// ============================================================================
`ifndef CIRCLE_PAIR_OVERLAP_RESOLVER_ASSERT_SVH
`define CIRCLE_PAIR_OVERLAP_RESOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPOR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpor: implication check failed");
`define CPOR_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("cpor: forbidden condition seen");
`else
`define CPOR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CPOR_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: src/cpor_pkg.sv
// ============================================================================
// cpor_pkg
// Widths, lane codes and sideband types shared by the resolver pipeline.
// ============================================================================
package cpor_pkg;

   localparam int POS_WIDTH = 24;
   localparam int DIFF_W    = POS_WIDTH + 1;
   localparam int RAD_W     = 16;
   localparam int MASS_W    = 16;
   localparam int RSUM_W    = RAD_W + 1;
   localparam int RSQ_W     = 2 * RSUM_W;
   localparam int D2_W      = RSQ_W + 1;
   localparam int FRAC_W    = 8;
   localparam int SQ_IN_W   = RSQ_W + 2 * FRAC_W;
   localparam int SQ_W      = SQ_IN_W + 1;
   localparam int ROOT_W    = SQ_IN_W / 2;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int PEN_W     = RSUM_W + FRAC_W;
   localparam int MDEN_W    = MASS_W + 1;
   localparam int DEN_W     = ROOT_W + MDEN_W;
   localparam int MP_W      = RSUM_W + PEN_W;
   localparam int PROD_W    = MP_W + MASS_W;
   localparam int DVD_W     = PROD_W + 2;
   localparam int DVS_W     = DEN_W + 1;
   localparam int Q_W       = RSUM_W + 1;
   localparam int DIV_STEPS = Q_W;
   localparam int REM_W     = DVD_W + 1;
   localparam int LANES     = 4;
   localparam int SUM_W     = ((POS_WIDTH > Q_W + 1) ? POS_WIDTH : Q_W + 1) + 1;
   localparam int REQ_W     = ((4 * POS_WIDTH + 2 * RAD_W + 2 * MASS_W + 7) / 8) * 8;
   localparam int RSP_W     = ((4 * POS_WIDTH + 1 + 7) / 8) * 8;

   // push can never exceed the penetration over 256
   localparam logic [Q_W-1:0] Q_MAX = Q_W'(1) << (Q_W - 1);

   // divider lanes
   localparam int LANE_FX = 0;
   localparam int LANE_FY = 1;
   localparam int LANE_SX = 2;
   localparam int LANE_SY = 3;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] x1;
      logic signed [POS_WIDTH-1:0] y1;
      logic signed [POS_WIDTH-1:0] x2;
      logic signed [POS_WIDTH-1:0] y2;
      logic [RSUM_W-1:0]           adx;
      logic [RSUM_W-1:0]           ady;
      logic                        sx;
      logic                        sy;
      logic [RSUM_W-1:0]           rsum;
      logic [MASS_W-1:0]           n1;
      logic [MASS_W-1:0]           n2;
      logic [MDEN_W-1:0]           mden;
      logic                        hit;
   } sq_side_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] x1;
      logic signed [POS_WIDTH-1:0] y1;
      logic signed [POS_WIDTH-1:0] x2;
      logic signed [POS_WIDTH-1:0] y2;
      logic                        sx;
      logic                        sy;
      logic                        hit;
   } dv_side_type;

endpackage

FILE: src/cpor_sqrt.sv
// ============================================================================
// cpor_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ============================================================================
module cpor_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [cpor_pkg::SQ_IN_W-1:0]   in_value,
   input  cpor_pkg::sq_side_type          in_side,
   output logic                           out_valid,
   output logic [cpor_pkg::ROOT_W-1:0]    out_root,
   output cpor_pkg::sq_side_type          out_side
);
   import cpor_pkg::*;

   logic [SQ_STEPS-1:0] valid_ff;
   logic [SQ_W-1:0]     rem_ff  [SQ_STEPS-1];
   logic [SQ_W-1:0]     root_ff [SQ_STEPS];
   sq_side_type         side_ff [SQ_STEPS];

   logic [SQ_W-1:0]     st_rem  [SQ_STEPS];
   logic [SQ_W-1:0]     st_root [SQ_STEPS];
   sq_side_type         st_side [SQ_STEPS];
   logic [SQ_W-1:0]     rem_in  [SQ_STEPS];
   logic [SQ_W-1:0]     root_in [SQ_STEPS];

   always_comb begin
      st_rem[0]  = SQ_W'(in_value);
      st_root[0] = '0;
      st_side[0] = in_side;
      for (int s = 1; s < SQ_STEPS; s++) begin
         st_rem[s]  = rem_ff[s-1];
         st_root[s] = root_ff[s-1];
         st_side[s] = side_ff[s-1];
      end
   end

   // one trial subtract per stage, bit weight 4^(steps-1-s)
   always_comb begin
      logic [SQ_W-1:0] b;
      logic [SQ_W-1:0] t;
      b = '0;
      t = '0;
      for (int s = 0; s < SQ_STEPS; s++) begin
         b = SQ_W'(1) << (2 * (SQ_STEPS - 1 - s));
         t = st_root[s] + b;
         if (st_rem[s] >= t) begin
            rem_in[s]  = st_rem[s] - t;
            root_in[s] = (st_root[s] >> 1) + b;
         end else begin
            rem_in[s]  = st_rem[s];
            root_in[s] = st_root[s] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[SQ_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < SQ_STEPS - 1; s++) begin
            rem_ff[s] <= rem_in[s];
         end
         for (int s = 0; s < SQ_STEPS; s++) begin
            root_ff[s] <= root_in[s];
            side_ff[s] <= st_side[s];
         end
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1][ROOT_W-1:0];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

FILE: src/cpor_div.sv
// ============================================================================
// cpor_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module cpor_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [cpor_pkg::DVD_W-1:0]     in_dvd [cpor_pkg::LANES],
   input  logic [cpor_pkg::DVS_W-1:0]     in_dvs,
   input  cpor_pkg::dv_side_type          in_side,
   output logic                           out_valid,
   output logic [cpor_pkg::Q_W-1:0]       out_q [cpor_pkg::LANES],
   output cpor_pkg::dv_side_type          out_side
);
   import cpor_pkg::*;

   logic [DIV_STEPS-1:0] valid_ff;
   logic [REM_W-1:0]     rem_ff [DIV_STEPS-1][LANES];
   logic [Q_W-1:0]       q_ff   [DIV_STEPS][LANES];
   logic [DVS_W-1:0]     dvs_ff [DIV_STEPS-1];
   dv_side_type          side_ff [DIV_STEPS];

   logic [REM_W-1:0]     st_rem [DIV_STEPS][LANES];
   logic [Q_W-1:0]       st_q   [DIV_STEPS][LANES];
   logic [DVS_W-1:0]     st_dvs [DIV_STEPS];
   dv_side_type          st_side [DIV_STEPS];
   logic [REM_W-1:0]     rem_in [DIV_STEPS][LANES];
   logic [Q_W-1:0]       q_in   [DIV_STEPS][LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         st_rem[0][l] = REM_W'(in_dvd[l]);
         st_q[0][l]   = '0;
      end
      st_dvs[0]  = in_dvs;
      st_side[0] = in_side;
      for (int s = 1; s < DIV_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            st_rem[s][l] = rem_ff[s-1][l];
            st_q[s][l]   = q_ff[s-1][l];
         end
         st_dvs[s]  = dvs_ff[s-1];
         st_side[s] = side_ff[s-1];
      end
   end

   // compare against the divisor aligned to this stage's quotient bit
   always_comb begin
      logic [REM_W-1:0] sh;
      logic             ge;
      sh = '0;
      ge = 1'b0;
      for (int s = 0; s < DIV_STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            sh = REM_W'(st_dvs[s]) << (DIV_STEPS - 1 - s);
            ge = (st_rem[s][l] >= sh);
            rem_in[s][l] = ge ? st_rem[s][l] - sh : st_rem[s][l];
            q_in[s][l]   = {st_q[s][l][Q_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < DIV_STEPS - 1; s++) begin
            rem_ff[s] <= rem_in[s];
            dvs_ff[s] <= st_dvs[s];
         end
         for (int s = 0; s < DIV_STEPS; s++) begin
            q_ff[s]    <= q_in[s];
            side_ff[s] <= st_side[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_q     = q_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

FILE: src/circle_pair_overlap_resolver.sv
// ============================================================================
// circle_pair_overlap_resolver
// Pushes two overlapping circles apart along the centre line, mass weighted.
// ============================================================================
//
//   channel | dir | handshake             | beat
//   --------+-----+-----------------------+----------------------------------
//   req     | in  | req_tvalid/req_tready | two circles: pos, radius, mass
//   rsp     | out | rsp_tvalid/rsp_tready | corrected positions, overlap flag
//
// Throughput is one beat per cycle while rsp is not stalled. A beat passes 52
// register stages: 4 before the square root, 25 square-root stages, 4 after it,
// 18 divider stages and the output register.
// Reset is synchronous and clears only the valid bits.
// The whole pipeline advances as one while the output register is empty or
// being taken; a stall on rsp freezes every stage and drops req_tready in the
// same cycle, so no beat is lost or repeated.
//
`include "circle_pair_overlap_resolver_assert.svh"

module circle_pair_overlap_resolver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // first_x, first_y, second_x, second_y, first_radius, second_radius,
   // first_mass, second_mass
   input  logic [cpor_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // new_first_x, new_first_y, new_second_x, new_second_y, overlap_found,
   // zero pad
   output logic [cpor_pkg::RSP_W-1:0]    rsp_tdata
);
   import cpor_pkg::*;

   // saturating position move by an unsigned push
   function automatic logic signed [POS_WIDTH-1:0] sat_move(
      input logic signed [POS_WIDTH-1:0] pos,
      input logic [Q_W-1:0]              push,
      input logic                        sub
   );
      logic signed [SUM_W-1:0] p;
      logic signed [SUM_W-1:0] d;
      logic signed [SUM_W-1:0] s;
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      p  = SUM_W'(pos);
      d  = SUM_W'($signed({1'b0, push}));
      s  = sub ? p - d : p + d;
      hi = (SUM_W'(1) <<< (POS_WIDTH - 1)) - SUM_W'(1);
      lo = -hi - SUM_W'(1);
      if (s > hi) begin
         return hi[POS_WIDTH-1:0];
      end else if (s < lo) begin
         return lo[POS_WIDTH-1:0];
      end
      return s[POS_WIDTH-1:0];
   endfunction

   // one enable for the whole pipe: move when the output slot frees up
   logic adv;

   logic signed [POS_WIDTH-1:0] in_x1, in_y1, in_x2, in_y2;
   logic [RAD_W-1:0]            in_r1, in_r2;
   logic [MASS_W-1:0]           in_m1, in_m2;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;

   // stage 1: differences, radius sum, mass shares
   logic signed [DIFF_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   sq_side_type              s1_in, s1_ff;
   // stage 2: magnitudes, box test
   logic [DIFF_W-1:0]        adx_full, ady_full;
   logic                     near2_in, near2_ff;
   sq_side_type              s2_in, s2_ff;
   // stage 3: squares
   logic [RSQ_W-1:0]         sqx_ff, sqy_ff, rsq_ff;
   logic                     near3_ff;
   sq_side_type              s3_ff;
   // stage 4: distance squared and exact overlap test
   logic [D2_W-1:0]          d2_in, d2_ff;
   sq_side_type              s4_in, s4_ff;
   // square root
   logic                     sq_valid;
   logic [ROOT_W-1:0]        sq_root;
   sq_side_type              sq_side;
   // stage 5: penetration and shared denominator
   logic [PEN_W-1:0]         pen_ff;
   logic [DEN_W-1:0]         den5_ff;
   sq_side_type              s5_ff;
   // stage 6: axis times penetration
   logic [MP_W-1:0]          mx_ff, my_ff;
   logic [DEN_W-1:0]         den6_ff;
   sq_side_type              s6_ff;
   // stage 7: times mass share
   logic [PROD_W-1:0]        p_ff [LANES];
   logic [DEN_W-1:0]         den7_ff;
   dv_side_type              s7_in, s7_ff;
   // stage 8: rounding offset folded into dividend
   logic [DVD_W-1:0]         dvd_ff [LANES];
   logic [DVS_W-1:0]         dvs_ff;
   dv_side_type              s8_ff;
   // divider
   logic                     dv_valid;
   logic [Q_W-1:0]           dv_q [LANES];
   dv_side_type              dv_side;
   logic                     push_over;
   // output register
   logic                        rsp_valid_ff;
   logic signed [POS_WIDTH-1:0] nx1_in, ny1_in, nx2_in, ny2_in;
   logic signed [POS_WIDTH-1:0] nx1_ff, ny1_ff, nx2_ff, ny2_ff;
   logic                        ovl_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   assign in_x1 = req_tdata[0 +: POS_WIDTH];
   assign in_y1 = req_tdata[POS_WIDTH +: POS_WIDTH];
   assign in_x2 = req_tdata[2 * POS_WIDTH +: POS_WIDTH];
   assign in_y2 = req_tdata[3 * POS_WIDTH +: POS_WIDTH];
   assign in_r1 = req_tdata[4 * POS_WIDTH +: RAD_W];
   assign in_r2 = req_tdata[4 * POS_WIDTH + RAD_W +: RAD_W];
   assign in_m1 = req_tdata[4 * POS_WIDTH + 2 * RAD_W +: MASS_W];
   assign in_m2 = req_tdata[4 * POS_WIDTH + 2 * RAD_W + MASS_W +: MASS_W];

   // ---- stage 1 ----------------------------------------------------------
   always_comb begin
      s1_in      = '0;
      s1_in.x1   = in_x1;
      s1_in.y1   = in_y1;
      s1_in.x2   = in_x2;
      s1_in.y2   = in_y2;
      s1_in.rsum = RSUM_W'(in_r1) + RSUM_W'(in_r2);
      // zero mass is fixed; first fixed wins, so the second takes it all
      priority if (in_m1 == '0) begin
         s1_in.n1   = '0;
         s1_in.n2   = MASS_W'(1);
         s1_in.mden = MDEN_W'(1);
      end else if (in_m2 == '0) begin
         s1_in.n1   = MASS_W'(1);
         s1_in.n2   = '0;
         s1_in.mden = MDEN_W'(1);
      end else begin
         s1_in.n1   = in_m2;
         s1_in.n2   = in_m1;
         s1_in.mden = MDEN_W'(in_m1) + MDEN_W'(in_m2);
      end
      dx_in = DIFF_W'(in_x1) - DIFF_W'(in_x2);
      dy_in = DIFF_W'(in_y1) - DIFF_W'(in_y2);
   end

   // ---- stage 2 ----------------------------------------------------------
   always_comb begin
      adx_full = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
      ady_full = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
      // each axis must lie inside the radius sum before squaring is safe
      near2_in = (adx_full < DIFF_W'(s1_ff.rsum)) && (ady_full < DIFF_W'(s1_ff.rsum));
      s2_in     = s1_ff;
      s2_in.adx = adx_full[RSUM_W-1:0];
      s2_in.ady = ady_full[RSUM_W-1:0];
      s2_in.sx  = dx_ff[DIFF_W-1];
      s2_in.sy  = dy_ff[DIFF_W-1];
   end

   // ---- stage 4 ----------------------------------------------------------
   always_comb begin
      d2_in     = D2_W'(sqx_ff) + D2_W'(sqy_ff);
      s4_in     = s3_ff;
      s4_in.hit = near3_ff && (d2_in != '0) && (d2_in < D2_W'(rsq_ff));
   end

   // ---- stage 7 side -----------------------------------------------------
   always_comb begin
      s7_in.x1  = s6_ff.x1;
      s7_in.y1  = s6_ff.y1;
      s7_in.x2  = s6_ff.x2;
      s7_in.y2  = s6_ff.y2;
      s7_in.sx  = s6_ff.sx;
      s7_in.sy  = s6_ff.sy;
      s7_in.hit = s6_ff.hit;
   end

   // ---- output stage -----------------------------------------------------
   always_comb begin
      if (dv_side.hit) begin
         // first circle adds its push along the sign, second subtracts it
         nx1_in = sat_move(dv_side.x1, dv_q[LANE_FX], dv_side.sx);
         ny1_in = sat_move(dv_side.y1, dv_q[LANE_FY], dv_side.sy);
         nx2_in = sat_move(dv_side.x2, dv_q[LANE_SX], !dv_side.sx);
         ny2_in = sat_move(dv_side.y2, dv_q[LANE_SY], !dv_side.sy);
      end else begin
         nx1_in = dv_side.x1;
         ny1_in = dv_side.y1;
         nx2_in = dv_side.x2;
         ny2_in = dv_side.y2;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= sq_valid;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         rsp_valid_ff <= dv_valid;
      end
   end

   // payload, held whenever the pipe is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         s1_ff    <= s1_in;

         near2_ff <= near2_in;
         s2_ff    <= s2_in;

         sqx_ff   <= RSQ_W'(s2_ff.adx) * RSQ_W'(s2_ff.adx);
         sqy_ff   <= RSQ_W'(s2_ff.ady) * RSQ_W'(s2_ff.ady);
         rsq_ff   <= RSQ_W'(s2_ff.rsum) * RSQ_W'(s2_ff.rsum);
         near3_ff <= near2_ff;
         s3_ff    <= s2_ff;

         d2_ff    <= d2_in;
         s4_ff    <= s4_in;

         pen_ff   <= PEN_W'({sq_side.rsum, FRAC_W'(0)}) - PEN_W'(sq_root);
         den5_ff  <= DEN_W'(sq_root) * DEN_W'(sq_side.mden);
         s5_ff    <= sq_side;

         mx_ff    <= MP_W'(s5_ff.adx) * MP_W'(pen_ff);
         my_ff    <= MP_W'(s5_ff.ady) * MP_W'(pen_ff);
         den6_ff  <= den5_ff;
         s6_ff    <= s5_ff;

         p_ff[LANE_FX] <= PROD_W'(mx_ff) * PROD_W'(s6_ff.n1);
         p_ff[LANE_FY] <= PROD_W'(my_ff) * PROD_W'(s6_ff.n1);
         p_ff[LANE_SX] <= PROD_W'(mx_ff) * PROD_W'(s6_ff.n2);
         p_ff[LANE_SY] <= PROD_W'(my_ff) * PROD_W'(s6_ff.n2);
         den7_ff  <= den6_ff;
         s7_ff    <= s7_in;

         // round to nearest: (2*prod + den) / (2*den)
         for (int l = 0; l < LANES; l++) begin
            dvd_ff[l] <= DVD_W'({p_ff[l], 1'b0}) + DVD_W'(den7_ff);
         end
         dvs_ff   <= {den7_ff, 1'b0};
         s8_ff    <= s7_ff;

         nx1_ff   <= nx1_in;
         ny1_ff   <= ny1_in;
         nx2_ff   <= nx2_in;
         ny2_ff   <= ny2_in;
         ovl_ff   <= dv_side.hit;
      end
   end

   // distance in units of 2^-8 from the squared distance
   cpor_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_value  ({d2_ff[RSQ_W-1:0], (2 * FRAC_W)'(0)}),
      .in_side   (s4_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // four pushes share one denominator
   cpor_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_ff),
      .in_dvd    (dvd_ff),
      .in_dvs    (dvs_ff),
      .in_side   (s8_ff),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({ovl_ff, ny2_ff, nx2_ff, ny1_ff, nx1_ff});

   assign push_over = (dv_q[LANE_FX] > Q_MAX) || (dv_q[LANE_FY] > Q_MAX)
                      || (dv_q[LANE_SX] > Q_MAX) || (dv_q[LANE_SY] > Q_MAX);

   // a confirmed overlap has a nonzero distance and a nonzero penetration
   `CPOR_ASSERT_IMPLY(a_hit_root, clock, reset, sq_valid && sq_side.hit, sq_root != '0)
   `CPOR_ASSERT_IMPLY(a_hit_pen, clock, reset, v5_ff && s5_ff.hit, pen_ff != '0)
   // no push may exceed the penetration bound
   `CPOR_ASSERT_NEVER(a_push_bound, clock, reset, dv_valid && dv_side.hit && push_over)

endmodule

FILE: verif/circle_pair_overlap_resolver_test.sv
// ============================================================================
// Circle pair overlap resolver testbench
// Drives circle pairs with random gaps and stalls; predicts each corrected
// pair with exact integer arithmetic and compares it field by field.
// ============================================================================
`timescale 1ns / 1ps

module circle_pair_overlap_resolver_test;
   import cpor_pkg::*;

   localparam int MAX_MISMATCH_SHOWN = 10;
   localparam int STALL_LIMIT        = 20000;
   localparam int DRAIN_CYCLES       = 80;
   localparam int RANDOM_PAIRS       = 400;

   typedef logic signed [POS_WIDTH-1:0] pos_type;

   typedef struct packed {
      logic [MASS_W-1:0]   m2;
      logic [MASS_W-1:0]   m1;
      logic [RAD_W-1:0]    r2;
      logic [RAD_W-1:0]    r1;
      pos_type             y2;
      pos_type             x2;
      pos_type             y1;
      pos_type             x1;
   } pair_type;

   typedef struct packed {
      logic                hit;
      pos_type             y2;
      pos_type             x2;
      pos_type             y1;
      pos_type             x1;
   } resolved_type;

   // integer square root, bit by bit
   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // rounded push on one axis, ties away from zero, sign of the axis delta
   function automatic longint axis_share(longint c, longint unsigned pen,
                                         longint unsigned num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (c < 0) ? longint'(-c) : c;
      q = (2 * (mag * pen * num) + den) / (2 * den);
      return (c < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic pos_type clip_pos(longint v);
      longint hi;
      hi = (longint'(1) << (POS_WIDTH - 1)) - 1;
      if (v > hi) return pos_type'(hi);
      if (v < -hi - 1) return pos_type'(-hi - 1);
      return pos_type'(v);
   endfunction

   function automatic resolved_type resolve_pair(pair_type p);
      resolved_type o;
      longint x1, y1, x2, y2, dx, dy;
      longint unsigned adx, ady, rs, d2, cdist, pen, n1, n2, md, den;
      x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
      dx = x1 - x2; dy = y1 - y2;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      rs = longint'(p.r1) + longint'(p.r2);
      o = '{hit: 1'b0, x1: p.x1, y1: p.y1, x2: p.x2, y2: p.y2};
      if (adx < rs && ady < rs) begin
         d2 = adx * adx + ady * ady;
         if (d2 > 0 && d2 < rs * rs) begin
            cdist = root_floor(d2 << 16);
            pen = (rs << 8) - cdist;
            if (p.m1 == 0) begin
               n1 = 0; n2 = 1; md = 1;
            end else if (p.m2 == 0) begin
               n1 = 1; n2 = 0; md = 1;
            end else begin
               n1 = p.m2; n2 = p.m1; md = longint'(p.m1) + longint'(p.m2);
            end
            den = cdist * md;
            o.x1 = clip_pos(x1 + axis_share(dx, pen, n1, den));
            o.y1 = clip_pos(y1 + axis_share(dy, pen, n1, den));
            o.x2 = clip_pos(x2 - axis_share(dx, pen, n2, den));
            o.y2 = clip_pos(y2 - axis_share(dy, pen, n2, den));
            o.hit = 1'b1;
         end
      end
      return o;
   endfunction

   class resolver_scoreboard;
      resolved_type pending[$];
      int           mismatches;

      function void note_pair(pair_type p);
         pending.push_back(resolve_pair(p));
      endfunction

      function void check_result(resolved_type got);
         resolved_type want;
         bit bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_MISMATCH_SHOWN)
               $display("unexpected result beat %h", got);
            return;
         end
         want = pending.pop_front();
         bad = (got.x1 !== want.x1) || (got.y1 !== want.y1) || (got.x2 !== want.x2)
               || (got.y2 !== want.y2) || (got.hit !== want.hit);
         if (bad) begin
            mismatches++;
            if (mismatches <= MAX_MISMATCH_SHOWN)
               $display("mismatch: expected x1 %0d y1 %0d x2 %0d y2 %0d hit %0b,",
                        want.x1, want.y1, want.x2, want.y2, want.hit,
                        " got x1 %0d y1 %0d x2 %0d y2 %0d hit %0b",
                        got.x1, got.y1, got.x2, got.y2, got.hit);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;  // first_x, first_y, second_x, second_y, radii, masses
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;  // new positions x1, y1, x2, y2, overlap_found, pad

   resolver_scoreboard board;
   pair_type          pairs[$];
   int                idle_cycles;

   circle_pair_overlap_resolver dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic pos_type rand_pos();
      return pos_type'($urandom);
   endfunction

   // circles near one another so that most pairs overlap
   function automatic pair_type close_pair();
      pair_type p;
      int span;
      p.r1 = $urandom_range(0, 99) < 80 ? 16'($urandom_range(1, 4000)) : 16'($urandom);
      p.r2 = $urandom_range(0, 99) < 80 ? 16'($urandom_range(1, 4000)) : 16'($urandom);
      span = int'(p.r1) + int'(p.r2);
      p.x1 = rand_pos();
      p.y1 = rand_pos();
      p.x2 = pos_type'(p.x1 + $signed($urandom_range(0, 2 * span)) - span);
      p.y2 = pos_type'(p.y1 + $signed($urandom_range(0, 2 * span)) - span);
      p.m1 = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom);
      p.m2 = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom);
      if ($urandom_range(0, 3) == 0) p.m1 = 16'($urandom_range(1, 5));
      return p;
   endfunction

   task automatic add_pair(pos_type x1, pos_type y1, pos_type x2, pos_type y2,
                           int r1, int r2, int m1, int m2);
      pairs.push_back('{m2: 16'(m2), m1: 16'(m1), r2: 16'(r2), r1: 16'(r1),
                        y2: y2, x2: x2, y1: y1, x1: x1});
   endtask

   task automatic build_stimulus();
      pos_type pmax, pmin;
      pmax = {1'b0, {(POS_WIDTH-1){1'b1}}};
      pmin = {1'b1, {(POS_WIDTH-1){1'b0}}};
      add_pair(0, 0, 100, 0, 256, 256, 1, 1);           // plain overlap, equal mass
      add_pair(0, 0, 0, 0, 256, 256, 3, 4);             // coincident centres
      add_pair(0, 0, 5000, 5000, 10, 10, 1, 1);         // far apart
      add_pair(0, 0, 100, 50, 256, 256, 0, 7);          // first fixed
      add_pair(0, 0, 100, 50, 256, 256, 7, 0);          // second fixed
      add_pair(0, 0, 100, 50, 256, 256, 0, 0);          // both fixed
      add_pair(0, 0, 1, 0, 0, 2, 65535, 1);             // tiny push
      add_pair(pmax, pmax, pmax - 10, pmax - 10, 65535, 65535, 1, 1);  // clip high
      add_pair(pmin, pmin, pmin + 10, pmin + 10, 65535, 65535, 1, 1);  // clip low
      add_pair(pmax, 0, pmin, 0, 65535, 65535, 1, 1);   // wrap-size difference
      add_pair(0, 0, 512, 0, 256, 256, 1, 1);           // exact touch
      add_pair(-300, 200, 200, -300, 65535, 65535, 65535, 65535);
      add_pair(0, 0, 0, 0, 0, 0, 0, 0);
      add_pair(pmin, pmax, pmax, pmin, 65535, 0, 65535, 0);
      add_pair(-1, -1, 1, 1, 3, 3, 1, 65535);
      repeat (RANDOM_PAIRS) begin
         if ($urandom_range(0, 99) < 80)
            pairs.push_back(close_pair());
         else
            pairs.push_back(pair_type'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      end
   endtask

   task automatic send_pairs();
      int gap;
      foreach (pairs[i]) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= pairs[i];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         board.note_pair(pairs[i]);
      end
      req_tvalid <= 1'b0;
   endtask

   // randomly stall the result side; some stretches never stall
   initial begin
      int hold;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // check each accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(resolved_type'(rsp_tdata[4*POS_WIDTH:0]));
   end

   // watchdog: count cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      board = new();
      idle_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      build_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pairs();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/cpor_pkg.sv
src/cpor_sqrt.sv
src/cpor_div.sv
src/circle_pair_overlap_resolver.sv
verif/circle_pair_overlap_resolver_test.sv
